### rtl/cst_triangle_stiffness_core_macros.svh
// Assertion macros of the triangle stiffness RTL.
`ifndef CST_TRIANGLE_STIFFNESS_CORE_MACROS_SVH
`define CST_TRIANGLE_STIFFNESS_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define CST_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define CST_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/cst_pkg.sv
// Package: types, widths and helper functions of the triangle stiffness core.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Field and datapath widths
    localparam int W_C    = 32;          // coordinates and material entries
    localparam int W_WT   = 16;          // integration weight
    localparam int W_G    = W_C + 1;     // coordinate differences
    localparam int W_P    = W_C + W_G;   // material times difference
    localparam int W_DG   = W_P + 1;     // sum of two such products
    localparam int DG_LO  = 34;          // low slice of a D*G term
    localparam int W_DGH  = W_DG - DG_LO;
    localparam int W_PH   = W_DGH + W_G;
    localparam int W_PL   = DG_LO + 1 + W_G;
    localparam int W_PD   = 2 * W_G;     // determinant products
    localparam int W_DET  = W_PD + 1;    // signed determinant
    localparam int W_DM   = W_DET - 1;   // determinant magnitude
    localparam int W_N0   = 100;         // unweighted numerator
    localparam int CHUNK  = 25;          // slice width for the weight product
    localparam int W_CP   = CHUNK + 1 + W_WT + 1;
    localparam int W_CT   = W_N0 - 3 * CHUNK;
    localparam int W_CTP  = W_CT + W_WT + 1;
    localparam int W_N    = 116;         // weighted numerator
    localparam int W_Q    = 64;          // quotient and result
    localparam int N_DIV  = W_Q;         // one quotient bit per stage

    localparam logic [2:0] ROW_LAST = 3'd5;
    localparam logic [W_Q-1:0] VAL_MAX = {1'b0, {(W_Q-1){1'b1}}};
    localparam logic [W_Q-1:0] VAL_MIN = {1'b1, {(W_Q-1){1'b0}}};
    localparam logic [W_WT-1:0] WEIGHT_RST = 16'h8000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_D11 = 3'd0,
        CFG_D12 = 3'd1,
        CFG_D13 = 3'd2,
        CFG_D22 = 3'd3,
        CFG_D23 = 3'd4,
        CFG_D33 = 3'd5,
        CFG_WT  = 3'd6
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic signed [W_C-1:0] node0_x;
        logic signed [W_C-1:0] node0_y;
        logic signed [W_C-1:0] node1_x;
        logic signed [W_C-1:0] node1_y;
        logic signed [W_C-1:0] node2_x;
        logic signed [W_C-1:0] node2_y;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [2:0]            row_index;
        logic [2:0]            col_index;
        logic signed [W_Q-1:0] stiffness_value;
        logic                  degenerate;
        logic                  last;
    } t_out;

    // Entry bookkeeping; neg holds the determinant sign until the numerator is known
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
        logic       degen;
        logic       zero;
        logic       neg;
        logic       ovf;
    } t_meta;

    typedef struct packed {
        t_meta            m;
        logic [W_DM-1:0]  det;
    } t_ectl;

    // One divider stage: remainder plus shared numerator/quotient shift word
    typedef struct packed {
        t_meta            m;
        logic [W_DM-1:0]  det;
        logic [W_DM-1:0]  rem;
        logic [W_Q-1:0]   sh;
    } t_dvs;

    // Produce one quotient bit by restoring subtraction
    function automatic t_dvs dv_step(input t_dvs s);
        logic [W_DM:0] t;
        t_dvs          r;
        r = s;
        t = {s.rem, s.sh[W_Q-1]};
        if (t >= {1'b0, s.det}) begin
            r.rem = W_DM'(t - {1'b0, s.det});
            r.sh  = {s.sh[W_Q-2:0], 1'b1};
        end else begin
            r.rem = t[W_DM-1:0];
            r.sh  = {s.sh[W_Q-2:0], 1'b0};
        end
        return r;
    endfunction

    // Apply sign and saturate the quotient
    function automatic logic [W_Q-1:0] sat_val(input t_dvs s);
        logic [W_Q-1:0] v;
        if (s.m.zero) begin
            v = '0;
        end else if (s.m.ovf) begin
            v = s.m.neg ? VAL_MIN : VAL_MAX;
        end else if (!s.m.neg) begin
            v = s.sh[W_Q-1] ? VAL_MAX : s.sh;
        end else begin
            v = (s.sh > VAL_MIN) ? VAL_MIN : (~s.sh + 1'b1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/cst_triangle_stiffness_core.sv
// Top level: constant strain triangle element stiffness pipeline.
//
// Usage: one input transaction carries the three node coordinates (Q16.16)
// of a linear triangle on the in channel (valid/ready). The block answers
// with 36 output transactions, the stiffness matrix in row-major order,
// each carrying row, column, the Q40.24 saturated entry, the degenerate flag
// and last on the 36th entry. Material matrix and weight are written on the
// cfg channel (index/data, always ready); the user must do so only while no
// element is in flight, which the block itself does not enforce. After the
// first entry of an element, entries leave one a cycle while the receiver
// does not stall. The entry sequencer issues one (row, column) entry a cycle,
// when not stalled, into a 64-stage restoring divider that yields one quotient bit per stage.
// A three-stage front end forms differences, products and the determinant
// and can take the next element while the current one is still issuing.
// Reset (synchronous, active low) empties every stage, clears the material
// matrix and sets the weight to one half. When the receiver stalls, the
// whole entry pipeline holds; the front end still fills its free stages.
`timescale 1ns / 1ps
`default_nettype none
`include "cst_triangle_stiffness_core_macros.svh"

module cst_triangle_stiffness_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cst_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cst_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);

    // Configuration registers
    logic signed [cst_pkg::W_C-1:0] r_d11, r_d12, r_d13, r_d22, r_d23, r_d33;
    logic [cst_pkg::W_WT-1:0]       r_wt;
    logic signed [cst_pkg::W_C-1:0] dm [3][3];

    // Control
    logic adv, e_last, buf_take, f1_rdy, f2_rdy, f3_rdy, in_acc;

    // Front end
    logic r_f1_valid, r_f2_valid, r_f3_valid;
    logic signed [cst_pkg::W_G-1:0]   r_f1_bq [3], r_f1_cq [3];
    logic signed [cst_pkg::W_G-1:0]   r_f2_bq [3], r_f2_cq [3];
    logic signed [cst_pkg::W_G-1:0]   r_f3_bq [3], r_f3_cq [3];
    logic signed [cst_pkg::W_PD-1:0]  r_f2_pa, r_f2_pb;
    logic signed [cst_pkg::W_P-1:0]   r_f2_p [3][6][2];
    logic signed [cst_pkg::W_DG-1:0]  r_f3_dg [3][6];
    logic signed [cst_pkg::W_DET-1:0] r_f3_det;

    // Element buffer and entry sequencer
    logic                            r_e_valid;
    logic [2:0]                      r_e_row, r_e_col;
    logic signed [cst_pkg::W_G-1:0]  r_b_bq [3], r_b_cq [3];
    logic signed [cst_pkg::W_DG-1:0] r_b_dg [3][6];
    logic [cst_pkg::W_DM-1:0]        r_b_det;
    logic                            r_b_dneg, r_b_zero, r_b_degen;
    logic [1:0]                      na;

    // Entry pipeline
    logic                             r_e1_v, r_e2_v, r_e3_v, r_e4_v, r_e5_v;
    cst_pkg::t_ectl                   r_e1_c, r_e2_c, r_e3_c, r_e4_c, r_e5_c;
    logic signed [cst_pkg::W_DG-1:0]  r_e1_dg [3];
    logic signed [cst_pkg::W_G-1:0]   r_e1_g [3];
    logic signed [cst_pkg::W_PH-1:0]  r_e2_ph [3];
    logic signed [cst_pkg::W_PL-1:0]  r_e2_pl [3];
    logic signed [cst_pkg::W_N0-1:0]  r_e3_num;
    logic signed [cst_pkg::W_CP-1:0]  r_e4_p [3];
    logic signed [cst_pkg::W_CTP-1:0] r_e4_pt;
    logic signed [cst_pkg::W_N-1:0]   r_e5_num;
    logic                             n_nneg;
    logic [cst_pkg::W_N-1:0]          n_nabs;
    logic [cst_pkg::W_DM-1:0]         n_rem0;

    // Divider stages and output
    logic            r_dv_v [cst_pkg::N_DIV+1];
    cst_pkg::t_dvs   r_dv   [cst_pkg::N_DIV+1];
    logic            r_out_valid;
    cst_pkg::t_out   r_out;

    // Handshakes
    assign adv         = !r_out_valid || i_out_ready;
    assign e_last      = (r_e_row == cst_pkg::ROW_LAST) && (r_e_col == cst_pkg::ROW_LAST);
    assign buf_take    = adv && (!r_e_valid || e_last);
    assign f3_rdy      = !r_f3_valid || buf_take;
    assign f2_rdy      = !r_f2_valid || f3_rdy;
    assign f1_rdy      = !r_f1_valid || f2_rdy;
    assign in_acc      = i_in_valid && f1_rdy;
    assign o_in_ready  = f1_rdy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d11 <= '0;
            r_d12 <= '0;
            r_d13 <= '0;
            r_d22 <= '0;
            r_d23 <= '0;
            r_d33 <= '0;
            r_wt  <= cst_pkg::WEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (cst_pkg::t_cfg_idx'(i_cfg_index))
                cst_pkg::CFG_D11: r_d11 <= i_cfg_data;
                cst_pkg::CFG_D12: r_d12 <= i_cfg_data;
                cst_pkg::CFG_D13: r_d13 <= i_cfg_data;
                cst_pkg::CFG_D22: r_d22 <= i_cfg_data;
                cst_pkg::CFG_D23: r_d23 <= i_cfg_data;
                cst_pkg::CFG_D33: r_d33 <= i_cfg_data;
                cst_pkg::CFG_WT:  r_wt  <= i_cfg_data[cst_pkg::W_WT-1:0];
                default: ;
            endcase
        end
    end

    // Expand the symmetric material matrix
    always_comb begin
        dm[0][0] = r_d11; dm[0][1] = r_d12; dm[0][2] = r_d13;
        dm[1][0] = r_d12; dm[1][1] = r_d22; dm[1][2] = r_d23;
        dm[2][0] = r_d13; dm[2][1] = r_d23; dm[2][2] = r_d33;
    end

    // Front-end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else begin
            if (f1_rdy) r_f1_valid <= in_acc;
            if (f2_rdy) r_f2_valid <= r_f1_valid;
            if (f3_rdy) r_f3_valid <= r_f2_valid;
        end
    end

    // Stage F1: coordinate differences
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_f1_bq[0] <= cst_pkg::W_G'(i_in_data.node1_y) - cst_pkg::W_G'(i_in_data.node2_y);
            r_f1_bq[1] <= cst_pkg::W_G'(i_in_data.node2_y) - cst_pkg::W_G'(i_in_data.node0_y);
            r_f1_bq[2] <= cst_pkg::W_G'(i_in_data.node0_y) - cst_pkg::W_G'(i_in_data.node1_y);
            r_f1_cq[0] <= cst_pkg::W_G'(i_in_data.node2_x) - cst_pkg::W_G'(i_in_data.node1_x);
            r_f1_cq[1] <= cst_pkg::W_G'(i_in_data.node0_x) - cst_pkg::W_G'(i_in_data.node2_x);
            r_f1_cq[2] <= cst_pkg::W_G'(i_in_data.node1_x) - cst_pkg::W_G'(i_in_data.node0_x);
        end
    end

    // Stage F2: determinant products and material products
    always_ff @(posedge i_clk) begin
        if (f2_rdy && r_f1_valid) begin
            r_f2_pa <= r_f1_cq[1] * r_f1_bq[0];
            r_f2_pb <= r_f1_bq[1] * r_f1_cq[0];
            for (int n = 0; n < 3; n++) begin
                r_f2_bq[n] <= r_f1_bq[n];
                r_f2_cq[n] <= r_f1_cq[n];
                for (int k = 0; k < 3; k++) begin
                    r_f2_p[k][2*n][0]   <= dm[k][0] * r_f1_bq[n];
                    r_f2_p[k][2*n][1]   <= dm[k][2] * r_f1_cq[n];
                    r_f2_p[k][2*n+1][0] <= dm[k][1] * r_f1_cq[n];
                    r_f2_p[k][2*n+1][1] <= dm[k][2] * r_f1_bq[n];
                end
            end
        end
    end

    // Stage F3: determinant and D*G sums
    always_ff @(posedge i_clk) begin
        if (f3_rdy && r_f2_valid) begin
            r_f3_det <= cst_pkg::W_DET'(r_f2_pa) - cst_pkg::W_DET'(r_f2_pb);
            for (int n = 0; n < 3; n++) begin
                r_f3_bq[n] <= r_f2_bq[n];
                r_f3_cq[n] <= r_f2_cq[n];
            end
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 6; c++) begin
                    r_f3_dg[k][c] <= cst_pkg::W_DG'(r_f2_p[k][c][0])
                                   + cst_pkg::W_DG'(r_f2_p[k][c][1]);
                end
            end
        end
    end

    // Element buffer valid and entry counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_row   <= '0;
            r_e_col   <= '0;
        end else if (buf_take) begin
            r_e_valid <= r_f3_valid;
            r_e_row   <= '0;
            r_e_col   <= '0;
        end else if (adv && r_e_valid) begin
            if (r_e_col == cst_pkg::ROW_LAST) begin
                r_e_col <= '0;
                r_e_row <= r_e_row + 3'd1;
            end else begin
                r_e_col <= r_e_col + 3'd1;
            end
        end
    end

    // Load the element buffer, taking the determinant magnitude
    always_ff @(posedge i_clk) begin
        if (buf_take && r_f3_valid) begin
            r_b_bq    <= r_f3_bq;
            r_b_cq    <= r_f3_cq;
            r_b_dg    <= r_f3_dg;
            r_b_dneg  <= r_f3_det[cst_pkg::W_DET-1];
            r_b_zero  <= (r_f3_det == '0);
            r_b_degen <= (r_f3_det == '0) || r_f3_det[cst_pkg::W_DET-1];
            r_b_det   <= r_f3_det[cst_pkg::W_DET-1]
                       ? cst_pkg::W_DM'(-r_f3_det) : cst_pkg::W_DM'(r_f3_det);
        end
    end

    // Entry pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
            r_e4_v <= 1'b0;
            r_e5_v <= 1'b0;
            for (int i = 0; i <= cst_pkg::N_DIV; i++) r_dv_v[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_e1_v <= r_e_valid;
            r_e2_v <= r_e1_v;
            r_e3_v <= r_e2_v;
            r_e4_v <= r_e3_v;
            r_e5_v <= r_e4_v;
            r_dv_v[0] <= r_e5_v;
            for (int i = 1; i <= cst_pkg::N_DIV; i++) r_dv_v[i] <= r_dv_v[i-1];
            r_out_valid <= r_dv_v[cst_pkg::N_DIV];
        end
    end

    assign na = r_e_row[2:1];

    // Stage E1: pick the D*G column and the G row for this entry
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e1_c.m.row   <= r_e_row;
            r_e1_c.m.col   <= r_e_col;
            r_e1_c.m.last  <= e_last;
            r_e1_c.m.degen <= r_b_degen;
            r_e1_c.m.zero  <= r_b_zero;
            r_e1_c.m.neg   <= r_b_dneg;
            r_e1_c.m.ovf   <= 1'b0;
            r_e1_c.det     <= r_b_det;
            for (int k = 0; k < 3; k++) r_e1_dg[k] <= r_b_dg[k][r_e_col];
            r_e1_g[0] <= r_e_row[0] ? '0 : r_b_bq[na];
            r_e1_g[1] <= r_e_row[0] ? r_b_cq[na] : '0;
            r_e1_g[2] <= r_e_row[0] ? r_b_bq[na] : r_b_cq[na];
        end
    end

    // Stage E2: split products of D*G by G
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e2_c <= r_e1_c;
            for (int k = 0; k < 3; k++) begin
                r_e2_ph[k] <= $signed(r_e1_dg[k][cst_pkg::W_DG-1:cst_pkg::DG_LO]) * r_e1_g[k];
                r_e2_pl[k] <= $signed({1'b0, r_e1_dg[k][cst_pkg::DG_LO-1:0]}) * r_e1_g[k];
            end
        end
    end

    // Stage E3: combine halves and sum over the strain rows
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e3_c   <= r_e2_c;
            r_e3_num <= (cst_pkg::W_N0'(r_e2_ph[0]) <<< cst_pkg::DG_LO) + cst_pkg::W_N0'(r_e2_pl[0])
                      + (cst_pkg::W_N0'(r_e2_ph[1]) <<< cst_pkg::DG_LO) + cst_pkg::W_N0'(r_e2_pl[1])
                      + (cst_pkg::W_N0'(r_e2_ph[2]) <<< cst_pkg::DG_LO) + cst_pkg::W_N0'(r_e2_pl[2]);
        end
    end

    // Stage E4: slice products with the integration weight
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e4_c <= r_e3_c;
            for (int j = 0; j < 3; j++) begin
                r_e4_p[j] <= $signed({1'b0, r_e3_num[j*cst_pkg::CHUNK +: cst_pkg::CHUNK]})
                           * $signed({1'b0, r_wt});
            end
            r_e4_pt <= $signed(r_e3_num[cst_pkg::W_N0-1:3*cst_pkg::CHUNK]) * $signed({1'b0, r_wt});
        end
    end

    // Stage E5: weighted numerator
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e5_c   <= r_e4_c;
            r_e5_num <= (cst_pkg::W_N'(r_e4_pt)   <<< (3 * cst_pkg::CHUNK))
                      + (cst_pkg::W_N'(r_e4_p[2]) <<< (2 * cst_pkg::CHUNK))
                      + (cst_pkg::W_N'(r_e4_p[1]) <<< cst_pkg::CHUNK)
                      +  cst_pkg::W_N'(r_e4_p[0]);
        end
    end

    // Magnitude of the numerator and its high part for the divider
    always_comb begin
        n_nneg = r_e5_num[cst_pkg::W_N-1];
        n_nabs = n_nneg ? cst_pkg::W_N'(-r_e5_num) : cst_pkg::W_N'(r_e5_num);
        n_rem0 = cst_pkg::W_DM'(n_nabs[cst_pkg::W_N-1:cst_pkg::W_Q]);
    end

    // Stage E6: sign, overflow check and divider entry
    // Divider: one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0].m.row   <= r_e5_c.m.row;
            r_dv[0].m.col   <= r_e5_c.m.col;
            r_dv[0].m.last  <= r_e5_c.m.last;
            r_dv[0].m.degen <= r_e5_c.m.degen;
            r_dv[0].m.zero  <= r_e5_c.m.zero;
            r_dv[0].m.neg   <= n_nneg ^ r_e5_c.m.neg;
            r_dv[0].m.ovf   <= (n_rem0 >= r_e5_c.det);
            r_dv[0].det     <= r_e5_c.det;
            r_dv[0].rem     <= n_rem0;
            r_dv[0].sh      <= n_nabs[cst_pkg::W_Q-1:0];
            for (int i = 1; i <= cst_pkg::N_DIV; i++) r_dv[i] <= cst_pkg::dv_step(r_dv[i-1]);
        end
    end

    // Output register: saturate and attach indexes
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.row_index       <= r_dv[cst_pkg::N_DIV].m.row;
            r_out.col_index       <= r_dv[cst_pkg::N_DIV].m.col;
            r_out.stiffness_value <= cst_pkg::sat_val(r_dv[cst_pkg::N_DIV]);
            r_out.degenerate      <= r_dv[cst_pkg::N_DIV].m.degen;
            r_out.last            <= r_dv[cst_pkg::N_DIV].m.last;
        end
    end

    // Checks
    `CST_ASSERT_IMP(a_seq_range, r_e_valid, (r_e_row <= cst_pkg::ROW_LAST) && (r_e_col <= cst_pkg::ROW_LAST), "entry counter out of range")
    `CST_ASSERT_IMP(a_last_pos, o_out_valid && o_out_data.last, (o_out_data.row_index == cst_pkg::ROW_LAST) && (o_out_data.col_index == cst_pkg::ROW_LAST), "last flag on wrong entry")
    `CST_ASSERT_NXT(a_buf_load, r_f3_valid && buf_take, r_e_valid && (r_e_row == 3'd0) && (r_e_col == 3'd0), "element buffer load lost")

endmodule

`default_nettype wire

### bench/tb_cst_triangle_stiffness_core.sv
// Testbench of the constant strain triangle stiffness core with its own integer predictor.
`timescale 1ns / 1ps

module tb_cst_triangle_stiffness_core;

    localparam logic [2:0] CFG_SPARE = 3'd7;   // no register behind it
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = -32'sh7FFF_FFFF - 1;
    localparam logic signed [255:0] Q_MAX = 256'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [255:0] Q_MIN = -Q_MAX - 1;

    // Value pinned by hand for every entry of one element
    typedef struct {
        bit                    on;
        logic signed [63:0]    val;
        bit                    degen;
    } t_pin;

    typedef struct {
        int           phase;
        cst_pkg::t_in nodes;
        t_pin         pin;
    } t_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    cst_pkg::t_in   i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    cst_pkg::t_out  o_out_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index = cst_pkg::CFG_D11;
    logic [31:0]    i_cfg_data = '0;

    // Shadow of the material matrix and weight
    logic signed [31:0] mat_shadow [6];
    logic [15:0]        weight_shadow;

    cst_pkg::t_out entry_q [$];
    t_pin   pin_q [$];
    int     fail_count = 0;
    int     idle_cycles = 0;
    int     hold_left = 0;
    bit     quiet = 1'b0;
    t_row   rows [$];

    cst_triangle_stiffness_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Work out the 36 stiffness entries of one element, exact integer arithmetic
    function automatic void predict_stiffness(input cst_pkg::t_in n, input t_pin p);
        logic signed [255:0] x0, y0, x1, y1, x2, y2, det, num, q;
        logic signed [255:0] bq [3];
        logic signed [255:0] cq [3];
        logic signed [255:0] g [3][6];
        logic signed [255:0] dm [3][3];
        logic signed [255:0] dg [3][6];
        logic signed [255:0] wt;
        bit   zero;
        cst_pkg::t_out e;
        x0 = $signed(n.node0_x); y0 = $signed(n.node0_y);
        x1 = $signed(n.node1_x); y1 = $signed(n.node1_y);
        x2 = $signed(n.node2_x); y2 = $signed(n.node2_y);
        det = (x0 - x2) * (y1 - y2) - (y0 - y2) * (x1 - x2);
        zero = (det == 0);
        bq[0] = y1 - y2; bq[1] = y2 - y0; bq[2] = y0 - y1;
        cq[0] = x2 - x1; cq[1] = x0 - x2; cq[2] = x1 - x0;
        for (int k = 0; k < 3; k++) begin
            g[0][2*k] = bq[k]; g[0][2*k+1] = 0;
            g[1][2*k] = 0;     g[1][2*k+1] = cq[k];
            g[2][2*k] = cq[k]; g[2][2*k+1] = bq[k];
        end
        dm[0][0] = mat_shadow[cst_pkg::CFG_D11]; dm[0][1] = mat_shadow[cst_pkg::CFG_D12];
        dm[0][2] = mat_shadow[cst_pkg::CFG_D13]; dm[1][0] = mat_shadow[cst_pkg::CFG_D12];
        dm[1][1] = mat_shadow[cst_pkg::CFG_D22]; dm[1][2] = mat_shadow[cst_pkg::CFG_D23];
        dm[2][0] = mat_shadow[cst_pkg::CFG_D13]; dm[2][1] = mat_shadow[cst_pkg::CFG_D23];
        dm[2][2] = mat_shadow[cst_pkg::CFG_D33];
        wt = $signed({1'b0, weight_shadow});
        for (int k = 0; k < 3; k++)
            for (int b = 0; b < 6; b++) begin
                dg[k][b] = 0;
                for (int m = 0; m < 3; m++)
                    dg[k][b] += dm[k][m] * g[m][b];
            end
        for (int a = 0; a < 6; a++)
            for (int b = 0; b < 6; b++) begin
                e.row_index  = 3'(a);
                e.col_index  = 3'(b);
                e.degenerate = (det <= 0);
                e.last       = (a == 5 && b == 5);
                if (zero) begin
                    e.stiffness_value = '0;
                end else begin
                    num = 0;
                    for (int k = 0; k < 3; k++)
                        num += g[k][a] * dg[k][b];
                    q = (num * wt) / det;
                    if (q > Q_MAX) q = Q_MAX;
                    if (q < Q_MIN) q = Q_MIN;
                    e.stiffness_value = q[63:0];
                end
                if (p.on) begin
                    e.stiffness_value = p.val;
                    e.degenerate = p.degen;
                end
                entry_q.insert(entry_q.size(), e);
            end
    endfunction

    // Observe every handshake at the rising edge
    always @(posedge i_clk) begin
        cst_pkg::t_out want;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                idle_cycles = 0;
                if (i_cfg_index == cst_pkg::CFG_WT)
                    weight_shadow = i_cfg_data[15:0];
                else if (i_cfg_index != CFG_SPARE)
                    mat_shadow[i_cfg_index] = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                idle_cycles = 0;
                predict_stiffness(i_in_data, pin_q.pop_front());
            end
            if (o_out_valid && i_out_ready) begin
                idle_cycles = 0;
                if (entry_q.size() == 0) begin
                    report_mismatch("entry with none expected", o_out_data.stiffness_value, 0);
                end else begin
                    want = entry_q.pop_front();
                    if (o_out_data.row_index !== want.row_index)
                        report_mismatch("row_index", o_out_data.row_index, want.row_index);
                    if (o_out_data.col_index !== want.col_index)
                        report_mismatch("col_index", o_out_data.col_index, want.col_index);
                    if (o_out_data.stiffness_value !== want.stiffness_value)
                        report_mismatch("stiffness_value", o_out_data.stiffness_value,
                                        want.stiffness_value);
                    if (o_out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", o_out_data.degenerate, want.degenerate);
                    if (o_out_data.last !== want.last)
                        report_mismatch("last", o_out_data.last, want.last);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_cst_triangle_stiffness_core failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    function automatic cst_pkg::t_in mk_nodes(input logic signed [31:0] ax, ay, bx, by,
                                              cx, cy);
        cst_pkg::t_in n;
        n.node0_x = ax; n.node0_y = ay;
        n.node1_x = bx; n.node1_y = by;
        n.node2_x = cx; n.node2_y = cy;
        return n;
    endfunction

    function automatic t_pin mk_pin(input bit on, input logic signed [63:0] val,
                                    input bit degen);
        t_pin p;
        p.on = on; p.val = val; p.degen = degen;
        return p;
    endfunction

    task automatic send_element(input cst_pkg::t_in n, input t_pin p);
        pin_q.insert(pin_q.size(), p);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= n;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Lower valid and wait for every expected entry
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (entry_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_material(input logic [31:0] m11, m12, m13, m22, m23, m33,
                                 input logic [15:0] w);
        drain();
        write_reg(cst_pkg::CFG_D11, m11);
        write_reg(cst_pkg::CFG_D12, m12);
        write_reg(cst_pkg::CFG_D13, m13);
        write_reg(cst_pkg::CFG_D22, m22);
        write_reg(cst_pkg::CFG_D23, m23);
        write_reg(cst_pkg::CFG_D33, m33);
        write_reg(cst_pkg::CFG_WT, {16'h0, w});
    endtask

    function automatic logic [31:0] rand_material;
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1, 600000) << 8;
            2:       return -($urandom_range(0, 3000) << 8);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic cst_pkg::t_in rand_nodes;
        cst_pkg::t_in n;
        logic signed [31:0] bx, by;
        bit [31:0] r [6];
        foreach (r[i]) r[i] = $urandom;
        n = mk_nodes(r[0], r[1], r[2], r[3], r[4], r[5]);
        case ($urandom_range(9))
            0, 1: ;   // anywhere in the full range
            2: begin
                // collinear or repeated node
                n.node2_x = n.node1_x + (n.node1_x - n.node0_x) * $urandom_range(0, 2);
                n.node2_y = n.node1_y + (n.node1_y - n.node0_y) * $urandom_range(0, 2);
            end
            default: begin
                // compact element near a random origin, either orientation
                bx = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                by = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                n = mk_nodes(bx, by,
                             bx + $signed($urandom_range(0, 32'h7_FFFF)), by,
                             bx, by + $signed($urandom_range(0, 32'h7_FFFF)));
                if ($urandom_range(3) == 0) n = mk_nodes(bx, by, n.node2_x, n.node2_y,
                                                         n.node1_x, n.node1_y);
                n.node1_y += $signed($urandom_range(0, 4095)) - 2048;
            end
        endcase
        return n;
    endfunction

    initial begin
        int phase;
        t_pin none;
        foreach (mat_shadow[i]) mat_shadow[i] = '0;
        weight_shadow = cst_pkg::WEIGHT_RST;
        none = mk_pin(0, 0, 0);

        // Directed elements: reset material, then typical, extreme, zero weight
        rows = '{
            '{0, mk_nodes(0, 0, 0, 0, 0, 0), mk_pin(1, 0, 1)},
            '{0, mk_nodes(0, 0, ONE, 0, 0, ONE), mk_pin(1, 0, 0)},
            '{0, mk_nodes(0, 0, 0, ONE, ONE, 0), mk_pin(1, 0, 1)},
            '{1, mk_nodes(0, 0, ONE, 0, 0, ONE), none},
            '{1, mk_nodes(0, 0, 0, ONE, ONE, 0), none},
            '{1, mk_nodes(0, 0, ONE, ONE, 2*ONE, 2*ONE), mk_pin(1, 0, 1)},
            '{1, mk_nodes(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), none},
            '{1, mk_nodes(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), none},
            '{1, mk_nodes(0, 0, CMAX, 0, CMAX, 1), none},
            '{1, mk_nodes(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), mk_pin(1, 0, 1)},
            '{2, mk_nodes(0, 0, CMAX, 0, CMAX, 1), none},
            '{2, mk_nodes(0, 0, CMAX, 1, CMAX, 0), none},
            '{2, mk_nodes(0, 0, ONE, 0, 0, ONE), none},
            '{2, mk_nodes(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), none},
            '{3, mk_nodes(0, 0, ONE, 0, 0, ONE), mk_pin(1, 0, 0)},
            '{3, mk_nodes(0, 0, 0, ONE, ONE, 0), mk_pin(1, 0, 1)},
            '{3, mk_nodes(0, 0, CMAX, 0, CMAX, 1), mk_pin(1, 0, 0)}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        phase = 0;
        foreach (rows[r]) begin
            if (rows[r].phase != phase) begin
                phase = rows[r].phase;
                case (phase)
                    1: begin
                        load_material(2000 << 8, 600 << 8, 0, 2000 << 8, 0, 700 << 8,
                                      16'h8000);
                        write_reg(CFG_SPARE, 32'hDEAD_BEEF);
                    end
                    2: load_material(CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, 16'hFFFF);
                    default: load_material(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 16'h0000);
                endcase
            end
            send_element(rows[r].nodes, rows[r].pin);
        end

        // Random elements, material changed now and then
        for (int i = 0; i < 430; i++) begin
            if (i % 60 == 0)
                load_material(rand_material(), rand_material(), rand_material(),
                              rand_material(), rand_material(), rand_material(),
                              ($urandom_range(3) == 0) ? 16'($urandom_range(1) * 16'hFFFF)
                                                        : 16'($urandom));
            if (i == 100) hold_left = HOLD_CYCLES;
            if (i == 200) drain();
            quiet = (i >= 250 && i < 330);
            send_element(rand_nodes(), none);
        end
        quiet = 1'b0;

        drain();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_cst_triangle_stiffness_core passed");
        else
            $display("tb_cst_triangle_stiffness_core failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_triangle_stiffness_core.sv
bench/tb_cst_triangle_stiffness_core.sv
